@@ rtl/pld_pkg.sv @@
package pld_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int B_FRAC    = 16;
    localparam int FOOT_BITS = 27;
    localparam int DIST_BITS = 42;
endpackage

@@ rtl/pld_if.sv @@
interface pld_in_if #(parameter int CB = 16) (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [CB-1:0] line_a_x, line_a_y, line_a_z;
    logic signed [CB-1:0] line_b_x, line_b_y, line_b_z;
    logic signed [CB-1:0] query_x, query_y, query_z;
    modport source (output valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y,
                    line_b_z, query_x, query_y, query_z, input ready);
    modport sink (input valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y,
                  line_b_z, query_x, query_y, query_z, output ready);
endinterface

interface pld_out_if (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [26:0] foot_x, foot_y, foot_z;
    logic [41:0] distance_squared;
    logic degenerate;
    modport source (output valid, foot_x, foot_y, foot_z, distance_squared, degenerate,
                    input ready);
    modport sink (input valid, foot_x, foot_y, foot_z, distance_squared, degenerate,
                  output ready);
endinterface

@@ rtl/point_line_distance_projector_top.sv @@
// Point-to-line projector for 3D integer points.
// Input channel: one beat carries line points A, B and query point P.
// Output channel: one beat carries the foot of the perpendicular (8 fraction
// bits, signed), the squared distance (8 fraction bits) and a flag that is set
// when A equals B (the projection factor is then zero and foot equals A).
// Throughput is one beat per cycle while the receiver does not stall. The
// pipeline has 59 register stages with 16-bit coordinates: two stages for
// the differences and dot products, one to load the restoring divider and
// one per quotient bit (the 35-bit dividend width plus 16 fraction bits),
// and five for the signed factor, projections, rounding, residual squares
// and the final sum. The divider accounts for most of the stages.
// The whole pipeline advances only when its last stage is empty or being
// taken, so when the receiver stalls every stage holds its beat; nothing is
// lost or repeated. Reset clears only the valid bits that travel along the
// pipeline; the data registers need none.
module point_line_distance_projector_top
    import pld_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pld_in_if.sink    i_in,
    pld_out_if.source o_out
);
    localparam int VW = COORD_BITS + 1;
    localparam int PW = 2 * VW + 2;          // dot product width
    localparam int NW = PW - 1;              // magnitude width
    localparam int QW = NW + B_FRAC;
    localparam int DEPTH = QW + 1;
    localparam int BW = QW + 1;              // signed quotient
    localparam int JW = BW + VW;             // b*v
    localparam int EW = JW + 2;
    localparam int SH = B_FRAC - FRAC_BITS;
    // The residual never exceeds |w|, so it fits in the coordinate width plus
    // the fraction bits and two more.
    localparam int RW = COORD_BITS + FRAC_BITS + 2;
    localparam int SQ = 2 * RW;
    localparam int SW = SQ + 2;
    localparam int TW = 3 * VW + 3 * VW + 3 * COORD_BITS + 2;

    logic en;
    logic [DEPTH+6:0] r_vld;
    assign en = !r_vld[DEPTH+6] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[DEPTH+5:0], i_in.valid};
    end

    // Stage 1: differences.
    logic signed [COORD_BITS-1:0] r_a [3];
    logic signed [VW-1:0] r_v [3], r_w [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= i_in.line_a_x; r_a[1] <= i_in.line_a_y; r_a[2] <= i_in.line_a_z;
            r_v[0] <= VW'(i_in.line_b_x) - VW'(i_in.line_a_x);
            r_v[1] <= VW'(i_in.line_b_y) - VW'(i_in.line_a_y);
            r_v[2] <= VW'(i_in.line_b_z) - VW'(i_in.line_a_z);
            r_w[0] <= VW'(i_in.query_x) - VW'(i_in.line_a_x);
            r_w[1] <= VW'(i_in.query_y) - VW'(i_in.line_a_y);
            r_w[2] <= VW'(i_in.query_z) - VW'(i_in.line_a_z);
        end
    end

    // Stage 2: dot products.
    logic signed [PW-1:0] r_c1, r_c2;
    logic signed [COORD_BITS-1:0] r_a2 [3];
    logic signed [VW-1:0] r_v2 [3], r_w2 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= PW'(r_w[0] * r_v[0]) + PW'(r_w[1] * r_v[1]) + PW'(r_w[2] * r_v[2]);
            r_c2 <= PW'(r_v[0] * r_v[0]) + PW'(r_v[1] * r_v[1]) + PW'(r_v[2] * r_v[2]);
            r_a2 <= r_a; r_v2 <= r_v; r_w2 <= r_w;
        end
    end

    logic [NW-1:0] n_num, n_den;
    logic [TW-1:0] n_tag, tag;
    logic neg, degen;
    assign n_num = r_c1[PW-1] ? NW'(-r_c1) : NW'(r_c1);
    assign n_den = (r_c2 == '0) ? NW'(1) : NW'(r_c2);
    assign n_tag = {r_c1[PW-1], r_c2 == '0, r_v2[0], r_v2[1], r_v2[2],
                    r_w2[0], r_w2[1], r_w2[2], r_a2[0], r_a2[1], r_a2[2]};

    logic [QW-1:0] quo_full;
    pld_divider #(.NW(NW), .TW(TW)) u_div (
        .i_clk(i_clk), .i_en(en),
        .i_num(n_num), .i_den(n_den),
        .i_tag(n_tag), .o_quo(quo_full), .o_tag(tag)
    );

    assign neg   = tag[TW-1];
    assign degen = tag[TW-2];

    // Stage A: signed factor.
    logic signed [BW-1:0] r_b;
    logic [TW-1:0] r_tg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (degen) r_b <= '0;
            else r_b <= neg ? -$signed({1'b0, quo_full}) : $signed({1'b0, quo_full});
            r_tg <= tag;
        end
    end
    logic signed [VW-1:0] sv [3], sw [3];
    logic signed [COORD_BITS-1:0] sa [3];
    logic sdeg;
    assign {sdeg, sv[0], sv[1], sv[2], sw[0], sw[1], sw[2], sa[0], sa[1], sa[2]} =
        r_tg[TW-2:0];

    // Stage B: projections and residuals at 16 fraction bits.
    logic signed [JW-1:0] r_p [3];
    logic signed [EW-1:0] r_e [3];
    logic signed [COORD_BITS-1:0] r_a3 [3];
    logic r_dg3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= JW'(r_b * sv[i]);
                r_e[i] <= (EW'(sw[i]) <<< B_FRAC) - EW'(r_b * sv[i]);
            end
            r_a3 <= sa; r_dg3 <= sdeg;
        end
    end

    // Rounding half up is an add of half then an arithmetic shift.
    function automatic logic signed [EW-1:0] rnd(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] h;
        h = (SH > 0) ? (EW'(1) <<< (SH > 0 ? SH - 1 : 0)) : '0;
        return (x + h) >>> SH;
    endfunction

    // Stage C: feet and rounded residuals.
    logic signed [EW:0] r_ft [3];
    logic signed [RW-1:0] r_rs [3];
    logic r_dg4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ft[i] <= (EW+1)'($signed(r_a3[i]) * (EW+1)'(2 ** FRAC_BITS))
                         + (EW+1)'(rnd(EW'(r_p[i])));
                r_rs[i] <= RW'(rnd(r_e[i]));
            end
            r_dg4 <= r_dg3;
        end
    end

    // Stage D: squares.
    logic [SQ-1:0] r_sq [3];
    logic signed [EW:0] r_ft5 [3];
    logic r_dg5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) r_sq[i] <= SQ'(r_rs[i] * r_rs[i]);
            r_ft5 <= r_ft; r_dg5 <= r_dg4;
        end
    end

    // Stage E: sum, round and saturate.
    localparam logic signed [EW:0] FHI = (EW+1)'(2 ** (FOOT_BITS - 1) - 1);
    localparam logic signed [EW:0] FLO = -FHI - 1;
    logic [SW-1:0] sum, sr;
    assign sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign sr = (FRAC_BITS > 0) ? ((sum + (SW'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)))
                                   >> FRAC_BITS) : sum;
    logic signed [FOOT_BITS-1:0] r_f [3];
    logic [DIST_BITS-1:0] r_d;
    logic r_dg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_ft5[i] > FHI) r_f[i] <= FOOT_BITS'(FHI);
                else if (r_ft5[i] < FLO) r_f[i] <= FOOT_BITS'(FLO);
                else r_f[i] <= FOOT_BITS'(r_ft5[i]);
            end
            r_d <= (sr > SW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}} : DIST_BITS'(sr);
            r_dg <= r_dg5;
        end
    end

    assign o_out.valid = r_vld[DEPTH+6];
    assign o_out.foot_x = r_f[0];
    assign o_out.foot_y = r_f[1];
    assign o_out.foot_z = r_f[2];
    assign o_out.distance_squared = r_d;
    assign o_out.degenerate = r_dg;
endmodule

@@ rtl/pld_divider.sv @@
module pld_divider
    import pld_pkg::*;
#(
    parameter int NW = 52,
    parameter int TW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [NW-1:0]          i_num,
    input  logic [NW-1:0]          i_den,
    input  logic [TW-1:0]          i_tag,
    output logic [NW+B_FRAC-1:0]   o_quo,
    output logic [TW-1:0]          o_tag
);
    // Restoring division, one quotient bit per stage; the quotient carries
    // B_FRAC fraction bits, so the numerator is pre-shifted.
    localparam int QW = NW + B_FRAC;
    logic [QW-1:0] r_q [QW+1];
    logic [NW:0]   r_r [QW+1];
    logic [NW-1:0] r_d [QW+1];
    logic [TW-1:0] r_t [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= {i_num, {B_FRAC{1'b0}}};
            r_r[0] <= '0;
            r_d[0] <= i_den;
            r_t[0] <= i_tag;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [NW+1:0] n_rem;
        logic [NW+1:0] n_dif;
        assign n_rem = {r_r[s], r_q[s][QW-1]};
        assign n_dif = n_rem - {2'b00, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s+1] <= r_d[s];
                r_t[s+1] <= r_t[s];
                if (!n_dif[NW+1]) begin
                    r_r[s+1] <= n_dif[NW:0];
                    r_q[s+1] <= {r_q[s][QW-2:0], 1'b1};
                end else begin
                    r_r[s+1] <= n_rem[NW:0];
                    r_q[s+1] <= {r_q[s][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_q[QW];
    assign o_tag = r_t[QW];
endmodule

@@ test/tb_point_line_distance_projector_top.sv @@
`timescale 1ns / 1ps

module tb_point_line_distance_projector_top
    import pld_pkg::*;
;

    localparam int CB          = COORD_BITS_DEF;
    localparam int RND_SHIFT   = B_FRAC - FRAC_BITS_DEF;
    localparam int NUM_RANDOM  = 1925;
    // Divider depth plus product and rounding stages, with margin.
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [CB-1:0] a [3];
        logic signed [CB-1:0] b [3];
        logic signed [CB-1:0] p [3];
    } t_query;

    typedef struct {
        logic signed [FOOT_BITS-1:0] foot [3];
        logic [DIST_BITS-1:0]        dist_sq;
        logic                        degen;
    } t_projection;

    // Holds the projections predicted for every accepted query, oldest first,
    // and compares each returned beat with the head of that list.
    class t_scoreboard;
        t_projection expected_q[$];
        int          errors;
        int          checked;
        int          degen_seen;

        function t_projection predict_projection(t_query q);
            t_projection       r;
            longint            v [3];
            longint            w [3];
            longint            c1, c2, bq, proj, foot, res;
            longint unsigned   num, quo, sum, dist_val;
            longint            foot_hi, foot_lo;
            c1 = 0;
            c2 = 0;
            bq = 0;
            sum = 0;
            foot_hi = (64'sd1 <<< (FOOT_BITS - 1)) - 1;
            foot_lo = -foot_hi - 1;
            for (int i = 0; i < 3; i++) begin
                v[i] = longint'(q.b[i]) - longint'(q.a[i]);
                w[i] = longint'(q.p[i]) - longint'(q.a[i]);
                c1 += w[i] * v[i];
                c2 += v[i] * v[i];
            end
            // The factor is the quotient truncated toward zero, 16 fraction bits.
            if (c2 != 0) begin
                num = (c1 < 0) ? -c1 : c1;
                quo = (num << B_FRAC) / longint'(c2);
                bq  = (c1 < 0) ? -longint'(quo) : longint'(quo);
            end
            for (int i = 0; i < 3; i++) begin
                proj = bq * v[i];
                // Arithmetic shift after adding half rounds ties toward plus infinity.
                foot = (longint'(q.a[i]) <<< FRAC_BITS_DEF)
                     + ((proj + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT);
                if (foot > foot_hi) foot = foot_hi;
                if (foot < foot_lo) foot = foot_lo;
                r.foot[i] = foot[FOOT_BITS-1:0];
                res = ((w[i] <<< B_FRAC) - proj + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
                sum += longint'(res * res);
            end
            dist_val = (sum + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
            if (dist_val > (64'd1 << DIST_BITS) - 1) dist_val = (64'd1 << DIST_BITS) - 1;
            r.dist_sq = dist_val[DIST_BITS-1:0];
            r.degen   = (c2 == 0);
            return r;
        endfunction

        function void note_query(t_query q);
            expected_q.push_back(predict_projection(q));
        endfunction

        function void check_projection(t_projection got);
            t_projection want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.degen) degen_seen++;
            for (int i = 0; i < 3; i++) begin
                if (got.foot[i] !== want.foot[i]) begin
                    $display("%0t: foot[%0d] expected %0d actual %0d",
                             $time, i, want.foot[i], got.foot[i]);
                    errors++;
                end
            end
            if (got.dist_sq !== want.dist_sq) begin
                $display("%0t: distance_squared expected %0d actual %0d",
                         $time, want.dist_sq, got.dist_sq);
                errors++;
            end
            if (got.degen !== want.degen) begin
                $display("%0t: degenerate expected %0b actual %0b",
                         $time, want.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pld_in_if #(.CB(CB)) in_if (i_clk);
    pld_out_if           out_if (i_clk);

    point_line_distance_projector_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_scoreboard scoreboard = new();
    int  queries_sent;
    int  idle_cycles = 0;
    bit  no_idle_send;
    bit  no_idle_recv;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Either side spends stretches with no idling at all; otherwise each beat
    // waits a random number of cycles.
    function automatic int draw_gap(bit no_idle);
        if (no_idle) return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic send_query(t_query q);
        int gap;
        if (queries_sent % 97 == 0) no_idle_send = ($urandom_range(0, 3) == 0);
        gap = draw_gap(no_idle_send);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.line_a_x <= q.a[0];
        in_if.line_a_y <= q.a[1];
        in_if.line_a_z <= q.a[2];
        in_if.line_b_x <= q.b[0];
        in_if.line_b_y <= q.b[1];
        in_if.line_b_z <= q.b[2];
        in_if.query_x  <= q.p[0];
        in_if.query_y  <= q.p[1];
        in_if.query_z  <= q.p[2];
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        scoreboard.note_query(q);
        queries_sent++;
    endtask

    task automatic send_coords(int ax, int ay, int az, int bx, int by, int bz,
                               int px, int py, int pz);
        t_query q;
        q.a = '{CB'(ax), CB'(ay), CB'(az)};
        q.b = '{CB'(bx), CB'(by), CB'(bz)};
        q.p = '{CB'(px), CB'(py), CB'(pz)};
        send_query(q);
    endtask

    function automatic logic signed [CB-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return CB'(-32768);
            1: return CB'(32767);
            2: return CB'(0);
            3: return CB'(-1);
            default: return CB'(1);
        endcase
    endfunction

    // Mixes full-range points, small clusters, coincident and nearly coincident
    // line points, query points on the line, and corners of the coordinate range.
    function automatic t_query random_query();
        t_query q;
        int     mode, k;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            q.a[i] = CB'($urandom());
            q.b[i] = CB'($urandom());
            q.p[i] = CB'($urandom());
            if (mode == 4 || mode == 5) begin
                q.a[i] = CB'($urandom_range(0, 127) - 64);
                q.b[i] = CB'($urandom_range(0, 127) - 64);
                q.p[i] = CB'($urandom_range(0, 127) - 64);
            end
            if (mode == 8) begin
                q.a[i] = extreme_coord();
                q.b[i] = extreme_coord();
                q.p[i] = extreme_coord();
            end
        end
        if (mode == 6) q.b = q.a;
        if (mode == 7) begin
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
                q.a[i] = CB'($urandom_range(0, 4095) - 2048);
                q.b[i] = CB'(q.a[i] + $urandom_range(0, 255) - 128);
                q.p[i] = CB'(q.a[i] + k * (q.b[i] - q.a[i]));
            end
        end
        if (mode == 9) begin
            for (int i = 0; i < 3; i++) begin
                q.b[i] = q.a[i] ^ CB'($urandom_range(0, 3));
            end
        end
        return q;
    endfunction

    // Receiver: stalls a random number of cycles before taking each beat.
    initial begin
        t_projection got;
        int          gap, taken;
        out_if.ready <= 1'b0;
        taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken % 89 == 0) no_idle_recv = ($urandom_range(0, 3) == 0);
            gap = draw_gap(no_idle_recv);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            got.foot    = '{out_if.foot_x, out_if.foot_y, out_if.foot_z};
            got.dist_sq = out_if.distance_squared;
            got.degen   = out_if.degenerate;
            scoreboard.check_projection(got);
            taken++;
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_point_line_distance_projector_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        queries_sent = 0;
        no_idle_send = 1'b0;
        no_idle_recv = 1'b0;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.line_a_x <= '0;
        in_if.line_a_y <= '0;
        in_if.line_a_z <= '0;
        in_if.line_b_x <= '0;
        in_if.line_b_y <= '0;
        in_if.line_b_z <= '0;
        in_if.query_x  <= '0;
        in_if.query_y  <= '0;
        in_if.query_z  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: coincident line points, corners of the range, query
        // points on the line, before and beyond its ends, and rounding ties.
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(5, -7, 9, 5, -7, 9, 100, 200, -300);
        send_coords(-32768, -32768, -32768, -32768, -32768, -32768,
                    32767, 32767, 32767);
        send_coords(-32768, -32768, -32768, 32767, 32767, 32767,
                    32767, -32768, 32767);
        send_coords(32767, 32767, 32767, -32768, -32768, -32768,
                    -32768, 32767, -32768);
        send_coords(-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768);
        send_coords(0, -32768, 0, 0, 32767, 0, -32768, -32768, 32767);
        send_coords(0, 0, -32768, 0, 0, 32767, 32767, 32767, 32767);
        send_coords(0, 0, 0, 10, 20, 30, 20, 40, 60);
        send_coords(0, 0, 0, 10, 20, 30, -30, -60, -90);
        send_coords(1, 1, 1, 2, 2, 2, 5, 5, 5);
        send_coords(0, 0, 0, 3, 0, 0, 1, 1, 0);
        send_coords(0, 0, 0, 3, 0, 0, -1, 1, 0);
        send_coords(0, 0, 0, 7, 3, 0, 1, 2, 3);
        send_coords(0, 0, 0, -7, -3, 0, 1, 2, 3);
        send_coords(-1, -1, -1, 0, 0, 0, -1, -1, -1);
        send_coords(0, 0, 0, 32767, 1, 0, -32768, -32768, -32768);
        send_coords(32767, -32768, 32767, 32766, -32767, 32767, -32768, 32767, -32768);
        send_coords(0, 0, 0, 1, 0, 0, 32767, 32767, 32767);
        send_coords(100, -100, 50, 100, -100, 51, -32768, 32767, 0);

        repeat (NUM_RANDOM) send_query(random_query());
        in_if.valid <= 1'b0;

        while (scoreboard.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d queries and checked %0d projections, %0d of them degenerate.",
                 queries_sent, scoreboard.checked, scoreboard.degen_seen);
        if (scoreboard.errors == 0 && scoreboard.expected_q.size() == 0) begin
            $display("tb_point_line_distance_projector_top passed");
        end else begin
            $display("tb_point_line_distance_projector_top failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/pld_pkg.sv
rtl/pld_if.sv
rtl/pld_divider.sv
rtl/point_line_distance_projector_top.sv
test/tb_point_line_distance_projector_top.sv
